FILE: rtl/sida_pkg.sv
// Shared constants and helpers for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sida_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 16;
    localparam int CHAR_WIDTH          = 8;
    localparam int DIGIT_WIDTH         = 4;

    // Shift-and-add-3 iterations folded into one pipeline stage
    localparam int DABBLE_STEP = 4;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

    // Decimal digits needed for the largest magnitude, 2^(width-1)
    function automatic int num_digits(input int width);
        longint unsigned v;
        int              n;
        v = longint'(1) << (width - 1);
        n = 0;
        while (v != 0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

FILE: rtl/sida_bcd_stage.sv
// One pipeline stage of the binary to BCD shift-and-add-3 conversion.
`timescale 1ns / 1ps

module sida_bcd_stage #(
    parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH,
    parameter int NUM_DIGITS  = sida_pkg::num_digits(VALUE_WIDTH),
    parameter int NUM_STEPS   = sida_pkg::DABBLE_STEP
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [NUM_DIGITS*sida_pkg::DIGIT_WIDTH-1:0] in_bcd,
    input  logic [VALUE_WIDTH-1:0]                    in_bin,
    input  logic                                      in_neg,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [NUM_DIGITS*sida_pkg::DIGIT_WIDTH-1:0] out_bcd,
    output logic [VALUE_WIDTH-1:0]                    out_bin,
    output logic                                      out_neg
);

    localparam int BCD_WIDTH = NUM_DIGITS * sida_pkg::DIGIT_WIDTH;

    logic                   valid_reg;
    logic [BCD_WIDTH-1:0]   bcd_reg;
    logic [BCD_WIDTH-1:0]   bcd_next;
    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic                   neg_reg;

    assign in_ready = !valid_reg || out_ready;

    // Correct each digit, then shift the next binary bit in
    always_comb begin
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int s = 0; s < NUM_STEPS; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (bcd_next[d*sida_pkg::DIGIT_WIDTH +: sida_pkg::DIGIT_WIDTH] >= 4'd5) begin
                    bcd_next[d*sida_pkg::DIGIT_WIDTH +: sida_pkg::DIGIT_WIDTH] =
                        bcd_next[d*sida_pkg::DIGIT_WIDTH +: sida_pkg::DIGIT_WIDTH] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_WIDTH-2:0], bin_next[VALUE_WIDTH-1]};
            bin_next = {bin_next[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
            neg_reg <= in_neg;
        end
    end

    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;
    assign out_neg   = neg_reg;

endmodule

FILE: rtl/sida_emitter.sv
// Serializer: turns a sign and BCD digits into one ASCII character per cycle while m_tready is high.
`timescale 1ns / 1ps

module sida_emitter #(
    parameter int NUM_DIGITS = sida_pkg::num_digits(sida_pkg::DEFAULT_VALUE_WIDTH)
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [NUM_DIGITS*sida_pkg::DIGIT_WIDTH-1:0] in_bcd,
    input  logic                                        in_neg,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [sida_pkg::CHAR_WIDTH-1:0]             m_tdata,
    output logic                                        m_tlast
);

    localparam int BCD_WIDTH = NUM_DIGITS * sida_pkg::DIGIT_WIDTH;
    localparam int POS_WIDTH = $clog2(NUM_DIGITS);

    logic                            busy_reg;
    logic                            busy_next;
    logic                            sign_reg;
    logic                            sign_next;
    logic [POS_WIDTH-1:0]            pos_reg;
    logic [POS_WIDTH-1:0]            pos_next;
    logic [BCD_WIDTH-1:0]            bcd_reg;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [sida_pkg::CHAR_WIDTH-1:0] m_data_reg;
    logic [sida_pkg::CHAR_WIDTH-1:0] m_data_next;
    logic                            m_last_reg;
    logic                            m_last_next;
    logic [POS_WIDTH-1:0]            msd_pos;
    logic [sida_pkg::DIGIT_WIDTH-1:0] digit;
    logic                            out_adv;
    logic                            emit;
    logic                            load;

    // Highest nonzero digit; zero prints a single '0'
    always_comb begin
        msd_pos = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (in_bcd[d*sida_pkg::DIGIT_WIDTH +: sida_pkg::DIGIT_WIDTH] != '0) begin
                msd_pos = POS_WIDTH'(d);
            end
        end
    end

    assign digit    = bcd_reg[pos_reg*sida_pkg::DIGIT_WIDTH +: sida_pkg::DIGIT_WIDTH];
    assign out_adv  = !m_valid_reg || m_tready;
    assign emit     = busy_reg && out_adv;
    assign in_ready = !busy_reg || (out_adv && !sign_reg && pos_reg == '0);
    assign load     = in_valid && in_ready;

    always_comb begin
        busy_next    = busy_reg;
        sign_next    = sign_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (out_adv) begin
            m_valid_next = busy_reg;
        end
        if (emit) begin
            if (sign_reg) begin
                m_data_next = sida_pkg::CHAR_MINUS;
                m_last_next = 1'b0;
                sign_next   = 1'b0;
            end else begin
                m_data_next = sida_pkg::CHAR_ZERO + {4'b0000, digit};
                m_last_next = (pos_reg == '0);
                if (pos_reg == '0) begin
                    busy_next = 1'b0;
                end else begin
                    pos_next = pos_reg - POS_WIDTH'(1);
                end
            end
        end
        if (load) begin
            busy_next = 1'b1;
            sign_next = in_neg;
            pos_next  = msd_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sign_reg   <= sign_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        if (load) begin
            bcd_reg <= in_bcd;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed two's-complement integer in, decimal ASCII characters out.
`timescale 1ns / 1ps

// Each request on the s_ side carries one signed integer of VALUE_WIDTH bits;
// the m_ side returns its decimal text, one ASCII character per request, most
// significant digit first, with leading zeros dropped, a '-' in front of a
// negative value, and m_tlast high on the final digit. Zero prints as "0" and
// the most negative value prints in full. A value's text has 1 to NUM_DIGITS+1
// characters (1 to 6 at 16 bits, "-32768" being the longest). A value goes
// through a negate stage and ceil(VALUE_WIDTH/4) shift-and-add-3 stages before
// the serializer, and m_tvalid rises with the first character once it has
// passed the negate register, every stage register and the serializer's output
// register. Values queue in the pipeline while the serializer is busy, and
// the next value's first character follows the previous run's last with no
// gap. Output data is registered, but ready ripples back through the stages
// without a register, so with every stage full m_tready reaches s_tready in
// the same cycle.

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,  // [VALUE_WIDTH-1:0] value, rest zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sida_pkg::CHAR_WIDTH-1:0] m_tdata,   // [7:0] character
    output logic                          m_tlast      // last character of the number
);

    localparam int NUM_DIGITS = sida_pkg::num_digits(VALUE_WIDTH);
    localparam int BCD_WIDTH  = NUM_DIGITS * sida_pkg::DIGIT_WIDTH;
    localparam int STEP       = sida_pkg::DABBLE_STEP;
    localparam int NUM_STAGES = (VALUE_WIDTH + STEP - 1) / STEP;

    // Pipeline links: index 0 is the negate stage, index NUM_STAGES feeds the serializer
    logic                   link_valid [NUM_STAGES+1];
    logic                   link_ready [NUM_STAGES+1];
    logic [BCD_WIDTH-1:0]   link_bcd   [NUM_STAGES+1];
    logic [VALUE_WIDTH-1:0] link_bin   [NUM_STAGES+1];
    logic                   link_neg   [NUM_STAGES+1];

    logic                   neg_valid_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   sign_reg;
    logic [VALUE_WIDTH-1:0] raw;

    // Negate stage: form the unsigned magnitude; -2^(W-1) maps to 2^(W-1) exactly
    assign raw      = s_tdata[VALUE_WIDTH-1:0];
    assign mag_next = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign s_tready = !neg_valid_reg || link_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_valid_reg <= 1'b0;
        end else if (s_tready) begin
            neg_valid_reg <= s_tvalid;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            mag_reg  <= mag_next;
            sign_reg <= raw[VALUE_WIDTH-1];
        end
    end

    assign link_valid[0] = neg_valid_reg;
    assign link_bcd[0]   = '0;
    assign link_bin[0]   = mag_reg;
    assign link_neg[0]   = sign_reg;

    // Shift-and-add-3 stages, four bit steps each; the last takes what is left
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
        localparam int STEPS = (g == NUM_STAGES - 1) ? (VALUE_WIDTH - STEP * g) : STEP;

        sida_bcd_stage #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .NUM_DIGITS  (NUM_DIGITS),
            .NUM_STEPS   (STEPS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_bcd    (link_bcd[g]),
            .in_bin    (link_bin[g]),
            .in_neg    (link_neg[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_bcd   (link_bcd[g+1]),
            .out_bin   (link_bin[g+1]),
            .out_neg   (link_neg[g+1])
        );
    end

    // Serialize sign and digits onto the output channel
    sida_emitter #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (link_valid[NUM_STAGES]),
        .in_ready (link_ready[NUM_STAGES]),
        .in_bcd   (link_bcd[NUM_STAGES]),
        .in_neg   (link_neg[NUM_STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: verif/sida_text_checker.sv
// Checker for the decimal ASCII converter: predicts each number's text and compares it.
`timescale 1ns / 1ps

module sida_text_checker #(
    parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH,
    parameter int DATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_WIDTH-1:0] s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  m_tlast,
    output int                    error_count,
    output int                    chars_pending,
    output int                    values_seen,
    output int                    negatives_seen,
    output int                    chars_seen
);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t pending_text[$];

    // Queue the characters of one number, sign first, then digits most significant first
    task automatic queue_decimal_text(input logic [VALUE_WIDTH-1:0] raw);
        logic [VALUE_WIDTH-1:0] mag_w;
        longint unsigned        mag;
        logic [3:0]             digit_buf[0:11];
        int                     n;
        int                     i;
        text_char_t             entry;
        mag_w = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
        mag   = longint'(mag_w);
        n     = 0;
        do begin
            digit_buf[n] = 4'(mag % 10);
            mag          = mag / 10;
            n++;
        end while (mag != 0);
        if (raw[VALUE_WIDTH-1]) begin
            entry.ch   = ASCII_MINUS;
            entry.last = 1'b0;
            pending_text.push_back(entry);
        end
        for (i = n - 1; i >= 0; i--) begin
            entry.ch   = ASCII_ZERO + 8'(digit_buf[i]);
            entry.last = (i == 0);
            pending_text.push_back(entry);
        end
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            error_count    = 0;
            chars_pending  = 0;
            values_seen    = 0;
            negatives_seen = 0;
            chars_seen     = 0;
        end else begin
            // Retire the output first; a request accepted now cannot answer in the same cycle
            if (m_tvalid && m_tready) begin
                chars_seen++;
                if (pending_text.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected character: expected none, actual 0x%02h last=%b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = pending_text.pop_front();
                    if (m_tdata !== want.ch) begin
                        error_count++;
                        $display("%0t: character mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, want.ch, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        error_count++;
                        $display("%0t: last mismatch: expected %b, actual %b (char 0x%02h)",
                                 $time, want.last, m_tlast, want.ch);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                values_seen++;
                if (s_tdata[VALUE_WIDTH-1])
                    negatives_seen++;
                queue_decimal_text(s_tdata[VALUE_WIDTH-1:0]);
            end
            chars_pending = pending_text.size();
        end
    end

endmodule

FILE: verif/tb_signed_int_to_decimal_ascii.sv
// Testbench top for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    localparam int VALUE_WIDTH  = sida_pkg::DEFAULT_VALUE_WIDTH;
    localparam int DATA_WIDTH   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_COUNT = 360;
    // Quiet cycles tolerated before the run is declared hung; stalls are short,
    // so this is generous
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 29;
    // Window of random requests with both sides running flat out
    localparam int STEADY_FIRST = 180;
    localparam int STEADY_LAST  = 260;

    localparam longint MAX_POS = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint MIN_NEG = -(longint'(1) <<< (VALUE_WIDTH - 1));

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_WIDTH-1:0] s_tdata  = '0;     // [VALUE_WIDTH-1:0] value, rest zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;           // [7:0] character
    logic                  m_tlast;

    int error_count;
    int chars_pending;
    int values_seen;
    int negatives_seen;
    int chars_seen;

    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;
    int quiet_cycles  = 0;

    always #4 aclk = ~aclk;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    sida_text_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .chars_pending (chars_pending),
        .values_seen   (values_seen),
        .negatives_seen(negatives_seen),
        .chars_seen    (chars_seen)
    );

    // Throttle the character sink: drop ready on a random share of cycles
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Count cycles with no handshake on either side; abort a hung run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one value and hold it until the converter takes the request.
    // Idle cycles are inserted before the offer; valid stays high between
    // back-to-back requests so it is never dropped and raised in one step.
    task automatic send_value(input longint val);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = DATA_WIDTH'($urandom);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = '0;
        s_tdata[VALUE_WIDTH-1:0] = VALUE_WIDTH'(val);
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // Pick a value, weighted toward every run length and the digit rollovers
    function automatic longint pick_value();
        longint mag;
        longint pow10;
        int     k;
        case ($urandom_range(0, 5))
            0: mag = longint'($urandom_range(0, 9));
            1: mag = longint'($urandom_range(10, 999));
            2: begin
                // Straddle a power of ten: 9..11, 99..101, ...
                pow10 = 1;
                for (k = $urandom_range(1, 4); k > 0; k--)
                    pow10 = pow10 * 10;
                mag = pow10 + longint'($urandom_range(0, 2)) - 1;
            end
            3: mag = MAX_POS - longint'($urandom_range(0, 3));
            default: return longint'($signed(VALUE_WIDTH'($urandom)));
        endcase
        if (mag > MAX_POS)
            mag = MAX_POS;
        if ($urandom_range(0, 1) == 1)
            return (mag == MAX_POS && $urandom_range(0, 1) == 1) ? MIN_NEG : -mag;
        return mag;
    endfunction

    initial begin
        longint directed[];
        int i;

        directed = '{
            0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 999, 1000, 9999, 10000,
            -10000, 12345, -23456, 20000, MAX_POS, MIN_NEG, MIN_NEG + 1,
            longint'($signed(16'h5555)), longint'($signed(16'hAAAA)), 255, 7
        };

        // Hold reset, then release it on a falling edge
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: zero, one-digit runs, each run length and both extremes
        foreach (directed[i])
            send_value(directed[i]);

        for (i = 0; i < RANDOM_COUNT; i++) begin
            // Run a stretch with no idling on either side
            send_idle_pct = (i >= STEADY_FIRST && i < STEADY_LAST) ? 0 : IDLE_PCT;
            recv_idle_pct = send_idle_pct;
            send_value(pick_value());
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        recv_idle_pct = IDLE_PCT;

        // Wait for the last characters, then give the pipeline time to show strays
        while (chars_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d values (%0d negative) into %0d characters,",
                 values_seen, negatives_seen, chars_seen);
        $display("covering zero, every run length and both signed extremes.");
        if (error_count == 0 && chars_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
